FILE: rtl/core/fwdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdf_pkg
// Types and constants shared by the decimal field formatter modules.
// ----------------------------------------------------------------------------
package fwdf_pkg;

    localparam int INT_DIGITS  = 10;
    localparam int FRAC_DIGITS = 9;
    localparam logic [32:0] INT_LIMIT = 33'd1000000000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_FIELD_WIDTH = 2'd0,
        CFG_DECIMALS    = 2'd1,
        CFG_ZERO_FILL   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        FR_IDLE, FR_MUL, FR_ROUND, FR_FRAC, FR_INT, FR_PUSH
    } front_state_t;

    // One rendered field, ready for character emission.
    typedef struct packed {
        logic [6:0]                        width;
        logic [3:0]                        dec;
        logic                              zero_fill;
        logic                              neg;
        status_t                           status;
        logic [3:0]                        int_count;
        logic [FRAC_DIGITS-1:0][3:0]       frac_dig;
        logic [INT_DIGITS-1:0][3:0]        int_dig;
    } field_desc_t;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        case (n)
            4'd0:    pow10 = 30'd1;
            4'd1:    pow10 = 30'd10;
            4'd2:    pow10 = 30'd100;
            4'd3:    pow10 = 30'd1000;
            4'd4:    pow10 = 30'd10000;
            4'd5:    pow10 = 30'd100000;
            4'd6:    pow10 = 30'd1000000;
            4'd7:    pow10 = 30'd10000000;
            4'd8:    pow10 = 30'd100000000;
            default: pow10 = 30'd1000000000;
        endcase
    endfunction

endpackage

FILE: rtl/core/fixed_width_decimal_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_unit
// Renders a sign-magnitude 32.32 fixed-point number as a right-aligned
// ASCII field, one character per output transaction.
// ----------------------------------------------------------------------------
// The front end takes a number, scales and rounds it, then extracts the fraction
// digits and then the integer digits one per cycle in its divide-by-ten unit and
// queues the result. The back end emits one character per cycle while the
// receiver is ready and then fetches the next descriptor. A two-entry queue lets
// both run together, so the sustained rate per number is set by the slower of
// the two. Configuration is sampled when a number is accepted.
module fixed_width_decimal_formatter_unit #(
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_DECIMALS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // is_negative, integer_part, fraction_part, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status
);

    logic [5:0] width_reg;
    logic [3:0] dec_reg;
    logic       zf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 6'd10;
            dec_reg   <= 4'd0;
            zf_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fwdf_pkg::CFG_FIELD_WIDTH: width_reg <= cfg_wdata;
                fwdf_pkg::CFG_DECIMALS:    dec_reg   <= cfg_wdata[3:0];
                fwdf_pkg::CFG_ZERO_FILL:   zf_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    fwdf_pkg::field_desc_t push_desc, pop_desc;
    logic push, full, pop, empty;

    fwdf_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_DECIMALS (MAX_DECIMALS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_width     (width_reg),
        .cfg_dec       (dec_reg),
        .cfg_zero_fill (zf_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_neg        (s_tdata[0]),
        .in_int        (s_tdata[32:1]),
        .in_frac       (s_tdata[64:33]),
        .q_push        (push),
        .q_full        (full),
        .q_desc        (push_desc)
    );

    fwdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_desc  (pop_desc)
    );

    fwdf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (empty),
        .q_pop      (pop),
        .q_desc     (pop_desc),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

endmodule

FILE: rtl/core/fwdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdf_front
// Accepts a number, scales and rounds it, extracts decimal digits one per
// cycle and classifies the field status.
// ----------------------------------------------------------------------------
module fwdf_front #(
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_DECIMALS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [5:0]            cfg_width,
    input  logic [3:0]            cfg_dec,
    input  logic                  cfg_zero_fill,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_neg,
    input  logic [31:0]           in_int,
    input  logic [31:0]           in_frac,
    output logic                  q_push,
    input  logic                  q_full,
    output fwdf_pkg::field_desc_t q_desc
);

    fwdf_pkg::front_state_t state_reg, state_next;

    logic                  neg_reg, zf_reg;
    logic [31:0]           ip_reg, fp_reg, im_reg;
    logic [32:0]           ie_reg;
    logic [6:0]            w_reg;
    logic [3:0]            dec_reg, k_reg, nd_reg;
    logic [63:0]           prod_reg;
    fwdf_pkg::status_t     status_reg;
    logic [fwdf_pkg::FRAC_DIGITS-1:0][3:0] fdig_reg;
    logic [fwdf_pkg::INT_DIGITS-1:0][3:0]  idig_reg;

    logic [6:0]  w_eff;
    logic [3:0]  dec_sat, dec_eff;
    logic [31:0] div_in, quo, rem;
    logic [63:0] recip_prod;
    logic [32:0] ie_round;
    logic [6:0]  room, need;

    // Effective width and decimals for the item being accepted.
    always_comb begin
        if (cfg_width == 6'd0) begin
            w_eff = 7'd1;
        end else if ({1'b0, cfg_width} > 7'(MAX_WIDTH)) begin
            w_eff = 7'(MAX_WIDTH);
        end else begin
            w_eff = {1'b0, cfg_width};
        end
        dec_sat = (cfg_dec > 4'(MAX_DECIMALS)) ? 4'(MAX_DECIMALS) : cfg_dec;
        if (dec_sat != 4'd0 && ({3'd0, dec_sat} + 7'd1 >= w_eff)) begin
            dec_eff = 4'd0;
        end else begin
            dec_eff = dec_sat;
        end
    end

    // Divide by ten through the reciprocal; one digit per cycle.
    assign div_in     = (state_reg == fwdf_pkg::FR_FRAC) ? im_reg : ie_reg[31:0];
    assign recip_prod = {32'd0, div_in} * 64'h0000_0000_CCCC_CCCD;
    assign quo        = {3'd0, recip_prod[63:35]};
    assign rem        = div_in - ((quo << 3) + (quo << 1));

    assign ie_round = {1'b0, ip_reg} + ((dec_reg == 4'd0) ? {32'd0, fp_reg[31]} : 33'd0);
    assign room     = w_reg - ((dec_reg != 4'd0) ? ({3'd0, dec_reg} + 7'd1) : 7'd0);
    assign need     = {3'd0, nd_reg} + 7'd1 + {6'd0, neg_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fwdf_pkg::FR_IDLE:  if (in_valid) state_next = fwdf_pkg::FR_MUL;
            fwdf_pkg::FR_MUL:   state_next = fwdf_pkg::FR_ROUND;
            fwdf_pkg::FR_ROUND: begin
                if (ie_round >= fwdf_pkg::INT_LIMIT) begin
                    state_next = fwdf_pkg::FR_PUSH;
                end else if (dec_reg != 4'd0) begin
                    state_next = fwdf_pkg::FR_FRAC;
                end else begin
                    state_next = fwdf_pkg::FR_INT;
                end
            end
            fwdf_pkg::FR_FRAC:  if (k_reg == dec_reg - 4'd1) state_next = fwdf_pkg::FR_INT;
            fwdf_pkg::FR_INT:   if (quo == 32'd0) state_next = fwdf_pkg::FR_PUSH;
            fwdf_pkg::FR_PUSH:  if (!q_full) state_next = fwdf_pkg::FR_IDLE;
            default:            state_next = fwdf_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (state_reg == fwdf_pkg::FR_IDLE);
        q_push   = (state_reg == fwdf_pkg::FR_PUSH) && !q_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fwdf_pkg::FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            fwdf_pkg::FR_IDLE: begin
                neg_reg <= in_neg;
                ip_reg  <= in_int;
                fp_reg  <= in_frac;
                w_reg   <= w_eff;
                dec_reg <= dec_eff;
                zf_reg  <= cfg_zero_fill;
                k_reg   <= 4'd0;
                nd_reg  <= 4'd0;
            end
            fwdf_pkg::FR_MUL: begin
                prod_reg <= {32'd0, fp_reg} * {34'd0, fwdf_pkg::pow10(dec_reg)};
            end
            fwdf_pkg::FR_ROUND: begin
                im_reg     <= 32'((prod_reg + 64'h0000_0000_8000_0000) >> 32);
                ie_reg     <= ie_round;
                status_reg <= (ie_round >= fwdf_pkg::INT_LIMIT) ? fwdf_pkg::ST_TOO_LARGE
                                                                : fwdf_pkg::ST_OK;
            end
            fwdf_pkg::FR_FRAC: begin
                fdig_reg[k_reg] <= rem[3:0];
                im_reg          <= quo;
                k_reg           <= k_reg + 4'd1;
                // carry out of the rounded fraction goes into the integer
                if (k_reg == dec_reg - 4'd1) ie_reg <= ie_reg + {1'b0, quo};
            end
            fwdf_pkg::FR_INT: begin
                idig_reg[nd_reg] <= rem[3:0];
                ie_reg           <= {1'b0, quo};
                nd_reg           <= nd_reg + 4'd1;
                if (quo == 32'd0 && need > room) status_reg <= fwdf_pkg::ST_NO_FIT;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        q_desc.width     = w_reg;
        q_desc.dec       = dec_reg;
        q_desc.zero_fill = zf_reg;
        q_desc.neg       = neg_reg;
        q_desc.status    = status_reg;
        q_desc.int_count = nd_reg;
        q_desc.frac_dig  = fdig_reg;
        q_desc.int_dig   = idig_reg;
    end

endmodule

FILE: rtl/core/fwdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdf_queue
// Two-entry queue of field descriptors between front and back.
// ----------------------------------------------------------------------------
module fwdf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fwdf_pkg::field_desc_t push_desc,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output fwdf_pkg::field_desc_t pop_desc
);

    fwdf_pkg::field_desc_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_desc = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/fwdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdf_back
// Walks a field descriptor left to right and emits one character per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module fwdf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  fwdf_pkg::field_desc_t q_desc,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  out_last,
    output logic [1:0]            out_status
);

    fwdf_pkg::field_desc_t cur_reg;
    logic       busy_reg, ovalid_reg, olast_reg;
    logic [6:0] pos_reg;
    logic [7:0] ochar_reg;
    logic [1:0] ostat_reg;

    logic       load_out, is_last;
    logic [6:0] r, fo, j;
    logic [7:0] ch;

    assign load_out = busy_reg && (!ovalid_reg || out_ready);
    assign is_last  = (pos_reg == cur_reg.width - 7'd1);
    assign q_pop    = !busy_reg && !q_empty;

    always_comb begin
        r  = cur_reg.width - 7'd1 - pos_reg;
        fo = (cur_reg.dec != 4'd0) ? ({3'd0, cur_reg.dec} + 7'd1) : 7'd0;
        j  = r - fo;
        if (cur_reg.status != fwdf_pkg::ST_OK) begin
            // keep the point inside a field of stars
            if (cur_reg.dec != 4'd0 && r == {3'd0, cur_reg.dec}) begin
                ch = fwdf_pkg::CH_POINT;
            end else begin
                ch = fwdf_pkg::CH_STAR;
            end
        end else if (r < fo) begin
            if (r < {3'd0, cur_reg.dec}) begin
                ch = fwdf_pkg::CH_ZERO | {4'd0, cur_reg.frac_dig[r[3:0]]};
            end else begin
                ch = fwdf_pkg::CH_POINT;
            end
        end else if (j < {3'd0, cur_reg.int_count}) begin
            ch = fwdf_pkg::CH_ZERO | {4'd0, cur_reg.int_dig[j[3:0]]};
        end else if (cur_reg.zero_fill) begin
            ch = (cur_reg.neg && pos_reg == 7'd0) ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_ZERO;
        end else begin
            ch = (cur_reg.neg && j == {3'd0, cur_reg.int_count}) ? fwdf_pkg::CH_MINUS
                                                                 : fwdf_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_desc;
        if (load_out) begin
            ochar_reg <= ch;
            olast_reg <= is_last;
            ostat_reg <= cur_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            pos_reg    <= 7'd0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                pos_reg  <= 7'd0;
            end else if (load_out) begin
                pos_reg <= pos_reg + 7'd1;
                if (is_last) busy_reg <= 1'b0;
            end
            if (load_out) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_char   = ochar_reg;
    assign out_last   = olast_reg;
    assign out_status = ostat_reg;

endmodule

FILE: tb/fixed_width_decimal_formatter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_unit_tb
// Self-checking bench for the decimal field formatter. It drives fixed-point
// numbers under several width, decimals and fill settings, predicts every
// character of each rendered field, and compares the output stream against it
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_unit_tb;

    typedef struct {
        logic [7:0]          ch;
        logic                last;
        fwdf_pkg::status_t   status;
    } field_char_t;

    class field_scoreboard;
        field_char_t pending_chars[$];
        int          errors;
        logic [5:0]  width_reg;
        logic [3:0]  dec_reg;
        logic        zero_fill_reg;

        function new();
            errors        = 0;
            width_reg     = 6'd10;
            dec_reg       = 4'd0;
            zero_fill_reg = 1'b0;
        endfunction

        function void set_reg(fwdf_pkg::cfg_index_t idx, logic [5:0] val);
            case (idx)
                fwdf_pkg::CFG_FIELD_WIDTH: width_reg     = val;
                fwdf_pkg::CFG_DECIMALS:    dec_reg       = val[3:0];
                fwdf_pkg::CFG_ZERO_FILL:   zero_fill_reg = val[0];
                default: ;
            endcase
        endfunction

        // Render one number into its field and queue the characters.
        function void note_number(logic neg, logic [31:0] ip, logic [31:0] fp);
            int unsigned         w, dec, ptr, k, i;
            logic [63:0]         iv, fv, p10;
            logic [7:0]          buf_c[32];
            fwdf_pkg::status_t   st;
            field_char_t         fc;
            w   = width_reg;
            dec = dec_reg;
            if (w == 0) w = 1;
            if (w > 32) w = 32;
            if (dec > 9) dec = 9;
            if (dec > 0 && dec + 1 >= w) dec = 0;
            st = fwdf_pkg::ST_OK;
            p10 = 1;
            for (k = 0; k < dec; k++) p10 = p10 * 10;
            if (dec > 0) begin
                fv = ({32'd0, fp} * p10 + 64'h8000_0000) >> 32;
                iv = {32'd0, ip};
            end else begin
                fv = 0;
                iv = {32'd0, ip} + fp[31];
            end
            if (iv >= 64'd1000000000) st = fwdf_pkg::ST_TOO_LARGE;
            ptr = w;
            if (st == fwdf_pkg::ST_OK && dec > 0) begin
                for (k = 0; k < dec; k++) begin
                    ptr--;
                    buf_c[ptr] = fwdf_pkg::CH_ZERO + 8'(fv % 10);
                    fv = fv / 10;
                end
                ptr--;
                buf_c[ptr] = fwdf_pkg::CH_POINT;
                iv = iv + fv;
            end
            while (st == fwdf_pkg::ST_OK) begin
                if (ptr == 0) begin
                    st = fwdf_pkg::ST_NO_FIT;
                end else begin
                    ptr--;
                    buf_c[ptr] = fwdf_pkg::CH_ZERO + 8'(iv % 10);
                    iv = iv / 10;
                    if (iv == 0) break;
                end
            end
            if (st == fwdf_pkg::ST_OK) begin
                if (zero_fill_reg) begin
                    if (neg && ptr == 0) st = fwdf_pkg::ST_NO_FIT;
                    else begin
                        while (ptr > 0) begin ptr--; buf_c[ptr] = fwdf_pkg::CH_ZERO; end
                        if (neg) buf_c[0] = fwdf_pkg::CH_MINUS;
                    end
                end else begin
                    if (neg && ptr == 0) st = fwdf_pkg::ST_NO_FIT;
                    else begin
                        if (neg) begin ptr--; buf_c[ptr] = fwdf_pkg::CH_MINUS; end
                        while (ptr > 0) begin ptr--; buf_c[ptr] = fwdf_pkg::CH_SPACE; end
                    end
                end
            end
            if (st != fwdf_pkg::ST_OK) begin
                for (i = 0; i < w; i++) buf_c[i] = fwdf_pkg::CH_STAR;
                if (dec > 0 && dec < w) buf_c[w - dec - 1] = fwdf_pkg::CH_POINT;
            end
            for (i = 0; i < w; i++) begin
                fc.ch     = buf_c[i];
                fc.last   = (i + 1 == w);
                fc.status = st;
                pending_chars.push_back(fc);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic [1:0] st);
            field_char_t exp_c;
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h", ch);
                errors++;
                return;
            end
            exp_c = pending_chars.pop_front();
            if (ch !== exp_c.ch) begin
                $error("character: expected %h actual %h", exp_c.ch, ch);
                errors++;
            end
            if (last !== exp_c.last) begin
                $error("is_last: expected %b actual %b", exp_c.last, last);
                errors++;
            end
            if (st !== exp_c.status) begin
                $error("status: expected %0d actual %0d", exp_c.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    field_scoreboard fields = new();
    int  idle_pct_src = 7;
    int  idle_pct_sink = 7;
    bit  sink_hold = 1'b0;
    int  quiet_cycles = 0;

    fixed_width_decimal_formatter_unit u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            fields.check_char(m_tdata, m_tlast, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold when requested.
    always @(negedge aclk)
        m_tready <= aresetn && !sink_hold && ($urandom_range(99) >= idle_pct_sink);

    task automatic write_reg(fwdf_pkg::cfg_index_t idx, logic [5:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        fields.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_number(logic neg, logic [31:0] ip, logic [31:0] fp);
        while ($urandom_range(99) < idle_pct_src) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, fp, ip, neg};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fields.note_number(neg, ip, fp);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (fields.pending_chars.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic send_random();
        logic [31:0] ip, fp;
        case ($urandom_range(4))
            0: ip = $urandom;
            1: ip = $urandom_range(999999999, 999999990);
            2: ip = $urandom_range(99);
            3: ip = 32'd1 * (10 ** $urandom_range(8)) - $urandom_range(1);
            default: ip = $urandom_range(99999);
        endcase
        case ($urandom_range(3))
            0: fp = 32'hFFFF_FFFF - $urandom_range(255);
            1: fp = 32'h8000_0000 + $urandom_range(3) - 2;
            default: fp = $urandom;
        endcase
        send_number($urandom_range(1), ip, fp);
    endtask

    initial begin
        int w_set[6] = '{1, 2, 4, 12, 20, 32};
        int phase;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset setting first, then extremes of every field.
        send_number(1'b0, 32'd0, 32'd0);
        send_number(1'b1, 32'd0, 32'd1);
        send_number(1'b0, 32'd999999999, 32'h7FFF_FFFF);
        send_number(1'b0, 32'd999999999, 32'h8000_0000);
        send_number(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_number(1'b1, 32'd123456789, 32'hFFFF_FFFF);
        drain();
        write_reg(fwdf_pkg::CFG_DECIMALS, 6'd3);
        write_reg(fwdf_pkg::CFG_ZERO_FILL, 6'd1);
        send_number(1'b1, 32'd42, 32'hFFFF_FFFF);
        send_number(1'b0, 32'd999999999, 32'hFFFF_FFFF);
        send_number(1'b1, 32'd12345, 32'h8000_0000);
        drain();
        write_reg(fwdf_pkg::CFG_FIELD_WIDTH, 6'd0);
        write_reg(fwdf_pkg::CFG_DECIMALS, 6'd15);
        send_number(1'b0, 32'd7, 32'd0);
        send_number(1'b1, 32'd0, 32'd0);
        drain();
        write_reg(fwdf_pkg::CFG_FIELD_WIDTH, 6'd63);
        send_number(1'b1, 32'd1, 32'h0000_0001);
        send_number(1'b0, 32'd999999999, 32'hFFFF_FFFF);
        drain();
        write_reg(fwdf_pkg::CFG_FIELD_WIDTH, 6'd10);
        write_reg(fwdf_pkg::CFG_DECIMALS, 6'd9);
        send_number(1'b0, 32'd5, 32'h1234_5678);
        drain();
        write_reg(fwdf_pkg::CFG_FIELD_WIDTH, 6'd11);
        send_number(1'b1, 32'd5, 32'h1234_5678);
        send_number(1'b0, 32'd5, 32'h1234_5678);
        drain();

        // Random phases over a range of settings.
        for (phase = 0; phase < 16; phase++) begin
            write_reg(fwdf_pkg::CFG_FIELD_WIDTH,
                      (phase % 5 == 4) ? 6'($urandom_range(63))
                                       : 6'(w_set[phase % 6]));
            write_reg(fwdf_pkg::CFG_DECIMALS,
                      (phase % 7 == 6) ? 6'($urandom_range(15))
                                       : 6'($urandom_range(9)));
            write_reg(fwdf_pkg::CFG_ZERO_FILL, 6'(phase & 1));
            idle_pct_src  = (phase == 3) ? 0 : 7;
            idle_pct_sink = (phase == 3) ? 0 : 7;
            if (phase == 8) begin
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (300) @(negedge aclk);
                        sink_hold = 1'b0;
                    end
                    repeat (8) send_random();
                join
            end
            repeat (28) send_random();
            drain();
        end

        if (fields.errors == 0 && fields.pending_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
